// ===== src/dqh_pkg.sv =====
// Shared types and codes for the deque with undo and redo history.
`timescale 1ns / 1ps
package dqh_pkg;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_UNDO       = 3'd4;
  localparam logic [2:0] CMD_REDO       = 3'd5;

  localparam int unsigned KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_PF   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PFW  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PB   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PBW  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_POPF = 3'd4;
  localparam logic [KIND_W-1:0] KIND_POPB = 3'd5;

  typedef enum logic [2:0] {
    RING_NONE,
    RING_PUSH_FRONT,
    RING_PUSH_BACK,
    RING_POP_FRONT,
    RING_POP_BACK
  } ring_op_e;

  typedef enum logic [1:0] {
    SRC_PUSH,
    SRC_FRONT,
    SRC_BACK,
    SRC_LOG
  } val_src_e;

  typedef struct packed {
    logic              accept;
    logic              rd_log;
    logic              rd_front;
    logic              rd_back;
    logic              cap_front;
    logic              cap_back;
    logic              exec;
    ring_op_e          store_op;
    val_src_e          store_src;
    logic              undo_push;
    logic              redo_push;
    logic              undo_pop;
    logic              redo_pop;
    logic [KIND_W-1:0] log_kind;
    val_src_e          log_src;
    logic              pop_take;
    val_src_e          pop_src;
    logic              applied;
    logic              load_out;
  } ctl_t;

  typedef struct packed {
    logic              store_full;
    logic              store_empty;
    logic              undo_empty;
    logic              redo_empty;
    logic [KIND_W-1:0] undo_kind;
    logic [KIND_W-1:0] redo_kind;
  } sts_t;

endpackage

// ===== src/deque_with_undo_redo_history_unit.sv =====
// Top level of the bounded deque with undo and redo logs.
`timescale 1ns / 1ps
// Each command word (push front/back, pop front/back, undo, redo) produces one
// result word. A new word is not accepted until the result of the last one has
// been loaded. The sequencer reads the top of both logs and the store's front
// and back through the single read port of each memory, applies the change in
// one update step, then reads the new front and back for the result. in_stall_o
// stays high while a word is in progress, including while its finished result
// waits behind a stalled output. The store and both logs are rings in RAM; no
// clearing pass is needed after reset.
module deque_with_undo_redo_history_unit #(
  parameter int unsigned STORE_DEPTH = 16,
  parameter int unsigned UNDO_DEPTH  = 16,
  parameter int unsigned REDO_DEPTH  = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         cmd_i,
  input  logic signed [31:0] push_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] popped_value_o,
  output logic signed [31:0] front_value_o,
  output logic signed [31:0] back_value_o,
  output logic [4:0]         store_count_o,
  output logic               store_empty_o,
  output logic               history_applied_o,
  output logic [4:0]         undo_entries_o,
  output logic [4:0]         redo_entries_o
);

  dqh_pkg::ctl_t ctl;
  dqh_pkg::sts_t sts;

  dqh_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i,
    .out_valid_o, .out_stall_i, .sts_i(sts), .ctl_o(ctl)
  );

  dqh_datapath #(
    .STORE_DEPTH(STORE_DEPTH), .UNDO_DEPTH(UNDO_DEPTH),
    .REDO_DEPTH(REDO_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk_i, .rst_ni, .ctl_i(ctl), .sts_o(sts), .push_value_i,
    .popped_value_o, .front_value_o, .back_value_o, .store_count_o,
    .store_empty_o, .history_applied_o, .undo_entries_o, .redo_entries_o
  );

endmodule

// ===== src/dqh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dqh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/dqh_ring.sv =====
// Head pointer and fill count of one circular buffer, with its derived addresses.
`timescale 1ns / 1ps
module dqh_ring #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dqh_pkg::ring_op_e op_i,
  output logic [AW-1:0]     head_o,
  output logic [AW-1:0]     tail_o,
  output logic [AW-1:0]     last_o,
  output logic [AW-1:0]     prev_o,
  output logic [CW-1:0]     fill_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);
  localparam logic [AW-1:0] TOP     = AW'(DEPTH - 1);

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW:0]   sum;
  logic [AW-1:0] next_head;

  // head + fill stays below twice the depth, so one subtract wraps it.
  always_comb begin
    sum = (CW + 1)'(head_q) + (CW + 1)'(fill_q);
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    tail_o = AW'(sum);
  end

  assign last_o    = (tail_o == '0) ? TOP : tail_o - AW'(1);
  assign prev_o    = (head_q == '0) ? TOP : head_q - AW'(1);
  assign next_head = (head_q == TOP) ? '0 : head_q + AW'(1);
  assign full_o    = (fill_q == CW'(DEPTH));
  assign empty_o   = (fill_q == '0);
  assign head_o    = head_q;
  assign fill_o    = fill_q;

  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    case (op_i)
      dqh_pkg::RING_PUSH_BACK: begin
        if (full_o) begin
          head_d = next_head;
        end else begin
          fill_d = fill_q + CW'(1);
        end
      end
      dqh_pkg::RING_PUSH_FRONT: begin
        head_d = prev_o;
        if (!full_o) begin
          fill_d = fill_q + CW'(1);
        end
      end
      dqh_pkg::RING_POP_FRONT: begin
        if (!empty_o) begin
          head_d = next_head;
          fill_d = fill_q - CW'(1);
        end
      end
      dqh_pkg::RING_POP_BACK: begin
        if (!empty_o) begin
          fill_d = fill_q - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

endmodule

// ===== src/dqh_datapath.sv =====
// Store and log memories, their ring pointers, operand and output registers.
`timescale 1ns / 1ps
module dqh_datapath #(
  parameter int unsigned STORE_DEPTH = 16,
  parameter int unsigned UNDO_DEPTH  = 16,
  parameter int unsigned REDO_DEPTH  = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dqh_pkg::ctl_t      ctl_i,
  output dqh_pkg::sts_t      sts_o,
  input  logic signed [31:0] push_value_i,
  output logic signed [31:0] popped_value_o,
  output logic signed [31:0] front_value_o,
  output logic signed [31:0] back_value_o,
  output logic [4:0]         store_count_o,
  output logic               store_empty_o,
  output logic               history_applied_o,
  output logic [4:0]         undo_entries_o,
  output logic [4:0]         redo_entries_o
);

  localparam int unsigned VW  = VALUE_WIDTH;
  localparam int unsigned KW  = dqh_pkg::KIND_W;
  localparam int unsigned SAW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned SCW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned UAW = (UNDO_DEPTH > 1) ? $clog2(UNDO_DEPTH) : 1;
  localparam int unsigned UCW = $clog2(UNDO_DEPTH + 1);
  localparam int unsigned RAW = (REDO_DEPTH > 1) ? $clog2(REDO_DEPTH) : 1;
  localparam int unsigned RCW = $clog2(REDO_DEPTH + 1);

  logic [VW-1:0]    pv_q, front_q, back_q, popped_q;
  logic             applied_q;

  logic [SAW-1:0]   s_head, s_tail, s_last, s_prev;
  logic [SCW-1:0]   s_fill;
  logic             s_full, s_empty;
  logic [UAW-1:0]   u_head, u_tail, u_last, u_prev;
  logic [UCW-1:0]   u_fill;
  logic             u_full, u_empty;
  logic [RAW-1:0]   r_head, r_tail, r_last, r_prev;
  logic [RCW-1:0]   r_fill;
  logic             r_full, r_empty;

  dqh_pkg::ring_op_e u_op, r_op;

  logic [VW-1:0]    s_rdata, log_val, store_wval, log_wval;
  logic [KW+VW-1:0] u_rdata, r_rdata;
  logic             s_we;
  logic [SAW-1:0]   s_waddr;

  assign u_op = ctl_i.undo_push ? dqh_pkg::RING_PUSH_BACK :
                ctl_i.undo_pop  ? dqh_pkg::RING_POP_BACK  : dqh_pkg::RING_NONE;
  assign r_op = ctl_i.redo_push ? dqh_pkg::RING_PUSH_BACK :
                ctl_i.redo_pop  ? dqh_pkg::RING_POP_BACK  : dqh_pkg::RING_NONE;

  dqh_ring #(.DEPTH(STORE_DEPTH)) u_store_ring (
    .clk_i, .rst_ni, .op_i(ctl_i.store_op),
    .head_o(s_head), .tail_o(s_tail), .last_o(s_last), .prev_o(s_prev),
    .fill_o(s_fill), .full_o(s_full), .empty_o(s_empty)
  );

  dqh_ring #(.DEPTH(UNDO_DEPTH)) u_undo_ring (
    .clk_i, .rst_ni, .op_i(u_op),
    .head_o(u_head), .tail_o(u_tail), .last_o(u_last), .prev_o(u_prev),
    .fill_o(u_fill), .full_o(u_full), .empty_o(u_empty)
  );

  dqh_ring #(.DEPTH(REDO_DEPTH)) u_redo_ring (
    .clk_i, .rst_ni, .op_i(r_op),
    .head_o(r_head), .tail_o(r_tail), .last_o(r_last), .prev_o(r_prev),
    .fill_o(r_fill), .full_o(r_full), .empty_o(r_empty)
  );

  // Only the undo log is popped by undo; otherwise a log value comes from redo.
  assign log_val = ctl_i.undo_pop ? u_rdata[VW-1:0] : r_rdata[VW-1:0];

  function automatic logic [VW-1:0] pick(input dqh_pkg::val_src_e src,
                                         input logic [VW-1:0] pv,
                                         input logic [VW-1:0] fr,
                                         input logic [VW-1:0] bk,
                                         input logic [VW-1:0] lg);
    logic [VW-1:0] r;
    case (src)
      dqh_pkg::SRC_PUSH:  r = pv;
      dqh_pkg::SRC_FRONT: r = fr;
      dqh_pkg::SRC_BACK:  r = bk;
      default:            r = lg;
    endcase
    return r;
  endfunction

  assign store_wval = pick(ctl_i.store_src, pv_q, front_q, back_q, log_val);
  assign log_wval   = pick(ctl_i.log_src, pv_q, front_q, back_q, log_val);
  assign s_we       = (ctl_i.store_op == dqh_pkg::RING_PUSH_FRONT) ||
                      (ctl_i.store_op == dqh_pkg::RING_PUSH_BACK);
  assign s_waddr    = (ctl_i.store_op == dqh_pkg::RING_PUSH_FRONT) ? s_prev : s_tail;

  dqh_ram #(.WIDTH(VW), .DEPTH(STORE_DEPTH)) u_store_ram (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(store_wval),
    .re_i(ctl_i.rd_front | ctl_i.rd_back),
    .raddr_i(ctl_i.rd_front ? s_head : s_last), .rdata_o(s_rdata)
  );

  dqh_ram #(.WIDTH(KW + VW), .DEPTH(UNDO_DEPTH)) u_undo_ram (
    .clk_i, .we_i(ctl_i.undo_push), .waddr_i(u_tail),
    .wdata_i({ctl_i.log_kind, log_wval}),
    .re_i(ctl_i.rd_log), .raddr_i(u_last), .rdata_o(u_rdata)
  );

  dqh_ram #(.WIDTH(KW + VW), .DEPTH(REDO_DEPTH)) u_redo_ram (
    .clk_i, .we_i(ctl_i.redo_push), .waddr_i(r_tail),
    .wdata_i({ctl_i.log_kind, log_wval}),
    .re_i(ctl_i.rd_log), .raddr_i(r_last), .rdata_o(r_rdata)
  );

  assign sts_o.store_full  = s_full;
  assign sts_o.store_empty = s_empty;
  assign sts_o.undo_empty  = u_empty;
  assign sts_o.redo_empty  = r_empty;
  assign sts_o.undo_kind   = u_rdata[KW+VW-1:VW];
  assign sts_o.redo_kind   = r_rdata[KW+VW-1:VW];

  // An empty store reads as zero at both ends.
  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      pv_q <= VW'(push_value_i);
    end
    if (ctl_i.cap_front) begin
      front_q <= s_empty ? '0 : s_rdata;
    end
    if (ctl_i.cap_back) begin
      back_q <= s_empty ? '0 : s_rdata;
    end
    if (ctl_i.exec) begin
      popped_q  <= ctl_i.pop_take ? pick(ctl_i.pop_src, pv_q, front_q, back_q, log_val) : '0;
      applied_q <= ctl_i.applied;
    end
    if (ctl_i.load_out) begin
      popped_value_o    <= 32'(popped_q);
      front_value_o     <= 32'(front_q);
      back_value_o      <= 32'(s_empty ? '0 : s_rdata);
      store_count_o     <= 5'(s_fill);
      store_empty_o     <= s_empty;
      history_applied_o <= applied_q;
      undo_entries_o    <= 5'(u_fill);
      redo_entries_o    <= 5'(r_fill);
    end
  end

endmodule

// ===== src/dqh_ctrl.sv =====
// Sequencer: walks each command through reads, one update step and result load.
`timescale 1ns / 1ps
module dqh_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [2:0]    cmd_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  dqh_pkg::sts_t sts_i,
  output dqh_pkg::ctl_t ctl_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_RD_PRE   = 3'd1;
  localparam logic [2:0] ST_RD_BACK  = 3'd2;
  localparam logic [2:0] ST_CAP_BACK = 3'd3;
  localparam logic [2:0] ST_EXEC     = 3'd4;
  localparam logic [2:0] ST_RD_POST  = 3'd5;
  localparam logic [2:0] ST_RD_POSTB = 3'd6;
  localparam logic [2:0] ST_FINISH   = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [2:0]    cmd_q;
  logic          out_valid_q, out_valid_d;
  logic          accept, out_free;
  dqh_pkg::ctl_t op;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  // Decode of the update cycle: store change, log traffic and popped value.
  always_comb begin
    op = '0;
    op.store_op  = dqh_pkg::RING_NONE;
    op.store_src = dqh_pkg::SRC_LOG;
    op.log_src   = dqh_pkg::SRC_LOG;
    op.pop_src   = dqh_pkg::SRC_FRONT;
    case (cmd_q)
      dqh_pkg::CMD_PUSH_FRONT: begin
        op.undo_push = 1'b1;
        op.log_kind  = sts_i.store_full ? dqh_pkg::KIND_PFW : dqh_pkg::KIND_PF;
        op.log_src   = sts_i.store_full ? dqh_pkg::SRC_BACK : dqh_pkg::SRC_PUSH;
        op.store_op  = dqh_pkg::RING_PUSH_FRONT;
        op.store_src = dqh_pkg::SRC_PUSH;
      end
      dqh_pkg::CMD_PUSH_BACK: begin
        op.undo_push = 1'b1;
        op.log_kind  = sts_i.store_full ? dqh_pkg::KIND_PBW : dqh_pkg::KIND_PB;
        op.log_src   = sts_i.store_full ? dqh_pkg::SRC_FRONT : dqh_pkg::SRC_PUSH;
        op.store_op  = dqh_pkg::RING_PUSH_BACK;
        op.store_src = dqh_pkg::SRC_PUSH;
      end
      dqh_pkg::CMD_POP_FRONT: begin
        if (!sts_i.store_empty) begin
          op.pop_take  = 1'b1;
          op.pop_src   = dqh_pkg::SRC_FRONT;
          op.undo_push = 1'b1;
          op.log_kind  = dqh_pkg::KIND_POPF;
          op.log_src   = dqh_pkg::SRC_FRONT;
          op.store_op  = dqh_pkg::RING_POP_FRONT;
        end
      end
      dqh_pkg::CMD_POP_BACK: begin
        if (!sts_i.store_empty) begin
          op.pop_take  = 1'b1;
          op.pop_src   = dqh_pkg::SRC_BACK;
          op.undo_push = 1'b1;
          op.log_kind  = dqh_pkg::KIND_POPB;
          op.log_src   = dqh_pkg::SRC_BACK;
          op.store_op  = dqh_pkg::RING_POP_BACK;
        end
      end
      dqh_pkg::CMD_UNDO: begin
        if (!sts_i.undo_empty) begin
          op.undo_pop  = 1'b1;
          op.redo_push = 1'b1;
          op.applied   = 1'b1;
          case (sts_i.undo_kind)
            dqh_pkg::KIND_PF: begin
              op.log_kind = dqh_pkg::KIND_PF;
              op.log_src  = dqh_pkg::SRC_FRONT;
              op.store_op = dqh_pkg::RING_POP_FRONT;
            end
            dqh_pkg::KIND_PFW: begin
              op.log_kind = dqh_pkg::KIND_PFW;
              op.log_src  = dqh_pkg::SRC_FRONT;
              op.store_op = dqh_pkg::RING_PUSH_BACK;
            end
            dqh_pkg::KIND_PB: begin
              op.log_kind = dqh_pkg::KIND_PB;
              op.log_src  = dqh_pkg::SRC_BACK;
              op.store_op = dqh_pkg::RING_POP_BACK;
            end
            dqh_pkg::KIND_PBW: begin
              op.log_kind = dqh_pkg::KIND_PBW;
              op.log_src  = dqh_pkg::SRC_BACK;
              op.store_op = dqh_pkg::RING_PUSH_FRONT;
            end
            dqh_pkg::KIND_POPF: begin
              op.log_kind = dqh_pkg::KIND_POPF;
              op.store_op = dqh_pkg::RING_PUSH_FRONT;
            end
            default: begin
              op.log_kind = dqh_pkg::KIND_POPB;
              op.store_op = dqh_pkg::RING_PUSH_BACK;
            end
          endcase
        end
      end
      dqh_pkg::CMD_REDO: begin
        if (!sts_i.redo_empty) begin
          op.redo_pop  = 1'b1;
          op.undo_push = 1'b1;
          op.applied   = 1'b1;
          case (sts_i.redo_kind)
            dqh_pkg::KIND_PF: begin
              op.log_kind = dqh_pkg::KIND_PF;
              op.store_op = dqh_pkg::RING_PUSH_FRONT;
            end
            dqh_pkg::KIND_PFW: begin
              op.log_kind = dqh_pkg::KIND_PFW;
              op.log_src  = dqh_pkg::SRC_BACK;
              op.store_op = dqh_pkg::RING_PUSH_FRONT;
            end
            dqh_pkg::KIND_PB: begin
              op.log_kind = dqh_pkg::KIND_PB;
              op.store_op = dqh_pkg::RING_PUSH_BACK;
            end
            dqh_pkg::KIND_PBW: begin
              op.log_kind = dqh_pkg::KIND_PBW;
              op.log_src  = dqh_pkg::SRC_FRONT;
              op.store_op = dqh_pkg::RING_PUSH_BACK;
            end
            dqh_pkg::KIND_POPF: begin
              op.log_kind = dqh_pkg::KIND_POPF;
              op.store_op = dqh_pkg::RING_POP_FRONT;
            end
            default: begin
              op.log_kind = dqh_pkg::KIND_POPB;
              op.store_op = dqh_pkg::RING_POP_BACK;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctl_o          = '0;
    ctl_o.store_op = dqh_pkg::RING_NONE;
    ctl_o.accept   = accept;
    state_d        = state_q;
    out_valid_d    = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RD_PRE;
        end
      end
      ST_RD_PRE: begin
        ctl_o.rd_log   = 1'b1;
        ctl_o.rd_front = 1'b1;
        state_d        = ST_RD_BACK;
      end
      ST_RD_BACK: begin
        ctl_o.cap_front = 1'b1;
        ctl_o.rd_back   = 1'b1;
        state_d         = ST_CAP_BACK;
      end
      ST_CAP_BACK: begin
        ctl_o.cap_back = 1'b1;
        state_d        = ST_EXEC;
      end
      ST_EXEC: begin
        ctl_o        = op;
        ctl_o.accept = 1'b0;
        ctl_o.exec   = 1'b1;
        state_d      = ST_RD_POST;
      end
      ST_RD_POST: begin
        ctl_o.rd_front = 1'b1;
        state_d        = ST_RD_POSTB;
      end
      ST_RD_POSTB: begin
        ctl_o.cap_front = 1'b1;
        ctl_o.rd_back   = 1'b1;
        state_d         = ST_FINISH;
      end
      ST_FINISH: begin
        // The back value sits in the store read register until the result loads.
        if (out_free) begin
          ctl_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
  end

endmodule

// ===== src/dqh_checker.sv =====
// Port-level assertions for the deque top level, bound to it.
`timescale 1ns / 1ps
module dqh_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] front_value_o,
  input logic signed [31:0] back_value_o,
  input logic [4:0]         store_count_o,
  input logic               store_empty_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !out_valid_o || in_stall_o)
    else $error("second word taken while one is in progress");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && store_empty_o |-> store_count_o == 5'd0)
    else $error("empty flag disagrees with count");

  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && store_empty_o |-> front_value_o == 32'sd0 && back_value_o == 32'sd0)
    else $error("empty store reports nonzero ends");

endmodule

bind deque_with_undo_redo_history_unit dqh_checker u_dqh_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .front_value_o, .back_value_o, .store_count_o, .store_empty_o
);

// ===== sim/tb_deque_with_undo_redo_history_unit.sv =====
// Self-checking testbench for the deque with undo and redo history.
`timescale 1ns / 1ps
module tb_deque_with_undo_redo_history_unit;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned MAX_CYCLES = 400000;

  typedef struct {
    logic [2:0]         cmd;
    logic signed [31:0] value;
  } cmd_word_t;

  typedef struct {
    logic signed [31:0] popped;
    logic signed [31:0] front;
    logic signed [31:0] back;
    logic [4:0]         count;
    logic               empty;
    logic               applied;
    logic [4:0]         undo_n;
    logic [4:0]         redo_n;
  } deque_view_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         cmd_i;
  logic signed [31:0] push_value_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] popped_value_o;
  logic signed [31:0] front_value_o;
  logic signed [31:0] back_value_o;
  logic [4:0]         store_count_o;
  logic               store_empty_o;
  logic               history_applied_o;
  logic [4:0]         undo_entries_o;
  logic [4:0]         redo_entries_o;

  deque_with_undo_redo_history_unit dut (.*);

  // Shadow copy of the deque and both logs.
  logic [31:0] ring_q[DEPTH];
  int unsigned ring_head, ring_fill;
  logic [2:0]  undo_kind_q[DEPTH];
  logic [31:0] undo_val_q[DEPTH];
  int unsigned undo_head, undo_fill;
  logic [2:0]  redo_kind_q[DEPTH];
  logic [31:0] redo_val_q[DEPTH];
  int unsigned redo_head, redo_fill;

  cmd_word_t   pending_words[$];
  deque_view_t expected_views[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  logic        stim_done;
  int          hold_cycles;
  int          in_gap, out_gap;

  function automatic logic [31:0] ring_front();
    return ring_fill != 0 ? ring_q[ring_head] : 32'd0;
  endfunction

  function automatic logic [31:0] ring_back();
    return ring_fill != 0 ? ring_q[(ring_head + ring_fill - 1) % DEPTH] : 32'd0;
  endfunction

  function automatic void ring_put_front(logic [31:0] v);
    if (ring_fill >= DEPTH) ring_fill = DEPTH - 1;
    ring_head = (ring_head + DEPTH - 1) % DEPTH;
    ring_q[ring_head] = v;
    ring_fill++;
  endfunction

  function automatic void ring_put_back(logic [31:0] v);
    if (ring_fill >= DEPTH) begin
      ring_head = (ring_head + 1) % DEPTH;
      ring_fill = DEPTH - 1;
    end
    ring_q[(ring_head + ring_fill) % DEPTH] = v;
    ring_fill++;
  endfunction

  function automatic logic [31:0] ring_take_front();
    logic [31:0] v;
    if (ring_fill == 0) return 32'd0;
    v = ring_q[ring_head];
    ring_head = (ring_head + 1) % DEPTH;
    ring_fill--;
    return v;
  endfunction

  function automatic logic [31:0] ring_take_back();
    if (ring_fill == 0) return 32'd0;
    ring_fill--;
    return ring_q[(ring_head + ring_fill) % DEPTH];
  endfunction

  // A full log drops its oldest entry to make room.
  function automatic void undo_append(logic [2:0] k, logic [31:0] v);
    if (undo_fill >= DEPTH) begin
      undo_head = (undo_head + 1) % DEPTH;
      undo_fill = DEPTH - 1;
    end
    undo_kind_q[(undo_head + undo_fill) % DEPTH] = k;
    undo_val_q[(undo_head + undo_fill) % DEPTH] = v;
    undo_fill++;
  endfunction

  function automatic void redo_append(logic [2:0] k, logic [31:0] v);
    if (redo_fill >= DEPTH) begin
      redo_head = (redo_head + 1) % DEPTH;
      redo_fill = DEPTH - 1;
    end
    redo_kind_q[(redo_head + redo_fill) % DEPTH] = k;
    redo_val_q[(redo_head + redo_fill) % DEPTH] = v;
    redo_fill++;
  endfunction

  function automatic deque_view_t apply_command(cmd_word_t w);
    deque_view_t r;
    logic [31:0] popped, d, t;
    logic [2:0]  k;
    logic        applied;
    popped = '0;
    applied = 1'b0;
    case (w.cmd)
      dqh_pkg::CMD_PUSH_FRONT: begin
        if (ring_fill >= DEPTH) undo_append(dqh_pkg::KIND_PFW, ring_back());
        else undo_append(dqh_pkg::KIND_PF, w.value);
        ring_put_front(w.value);
      end
      dqh_pkg::CMD_PUSH_BACK: begin
        if (ring_fill >= DEPTH) undo_append(dqh_pkg::KIND_PBW, ring_front());
        else undo_append(dqh_pkg::KIND_PB, w.value);
        ring_put_back(w.value);
      end
      dqh_pkg::CMD_POP_FRONT: begin
        if (ring_fill != 0) begin
          popped = ring_take_front();
          undo_append(dqh_pkg::KIND_POPF, popped);
        end
      end
      dqh_pkg::CMD_POP_BACK: begin
        if (ring_fill != 0) begin
          popped = ring_take_back();
          undo_append(dqh_pkg::KIND_POPB, popped);
        end
      end
      dqh_pkg::CMD_UNDO: begin
        if (undo_fill != 0) begin
          undo_fill--;
          k = undo_kind_q[(undo_head + undo_fill) % DEPTH];
          d = undo_val_q[(undo_head + undo_fill) % DEPTH];
          applied = 1'b1;
          case (k)
            dqh_pkg::KIND_PF: redo_append(k, ring_take_front());
            dqh_pkg::KIND_PFW: begin
              t = ring_front();
              ring_put_back(d);
              redo_append(k, t);
            end
            dqh_pkg::KIND_PB: redo_append(k, ring_take_back());
            dqh_pkg::KIND_PBW: begin
              redo_append(k, ring_back());
              ring_put_front(d);
            end
            dqh_pkg::KIND_POPF: begin
              ring_put_front(d);
              redo_append(k, d);
            end
            default: begin
              ring_put_back(d);
              redo_append(dqh_pkg::KIND_POPB, d);
            end
          endcase
        end
      end
      dqh_pkg::CMD_REDO: begin
        if (redo_fill != 0) begin
          redo_fill--;
          k = redo_kind_q[(redo_head + redo_fill) % DEPTH];
          d = redo_val_q[(redo_head + redo_fill) % DEPTH];
          applied = 1'b1;
          case (k)
            dqh_pkg::KIND_PF: begin
              undo_append(k, d);
              ring_put_front(d);
            end
            dqh_pkg::KIND_PFW: begin
              undo_append(k, ring_back());
              ring_put_front(d);
            end
            dqh_pkg::KIND_PB: begin
              undo_append(k, d);
              ring_put_back(d);
            end
            dqh_pkg::KIND_PBW: begin
              undo_append(k, ring_front());
              ring_put_back(d);
            end
            dqh_pkg::KIND_POPF: begin
              undo_append(k, d);
              void'(ring_take_front());
            end
            default: begin
              undo_append(dqh_pkg::KIND_POPB, d);
              void'(ring_take_back());
            end
          endcase
        end
      end
      default: ;
    endcase
    r.popped = popped;
    r.front = ring_front();
    r.back = ring_back();
    r.count = 5'(ring_fill);
    r.empty = ring_fill == 0;
    r.applied = applied;
    r.undo_n = 5'(undo_fill);
    r.redo_n = 5'(redo_fill);
    return r;
  endfunction

  function automatic void queue_word(logic [2:0] c, logic [31:0] v);
    cmd_word_t w;
    w.cmd = c;
    w.value = v;
    pending_words.insert(pending_words.size(), w);
  endfunction

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    int n;
    ring_head = 0; ring_fill = 0;
    undo_head = 0; undo_fill = 0;
    redo_head = 0; redo_fill = 0;
    // Directed: empty pops and history, unused codes, extremes, overflow evictions.
    queue_word(dqh_pkg::CMD_POP_FRONT, 32'h0);
    queue_word(dqh_pkg::CMD_POP_BACK, 32'h0);
    queue_word(dqh_pkg::CMD_UNDO, 32'h0);
    queue_word(dqh_pkg::CMD_REDO, 32'h0);
    queue_word(3'd6, 32'hffff_ffff);
    queue_word(3'd7, 32'h0);
    queue_word(dqh_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
    queue_word(dqh_pkg::CMD_PUSH_BACK, 32'h7fff_ffff);
    queue_word(dqh_pkg::CMD_PUSH_BACK, 32'hffff_ffff);
    queue_word(dqh_pkg::CMD_POP_FRONT, 32'h0);
    queue_word(dqh_pkg::CMD_UNDO, 32'h0);
    queue_word(dqh_pkg::CMD_REDO, 32'h0);
    for (int i = 0; i < 14; i++) queue_word(dqh_pkg::CMD_PUSH_BACK, $urandom);
    queue_word(dqh_pkg::CMD_PUSH_FRONT, 32'h1234_5678);
    queue_word(dqh_pkg::CMD_PUSH_BACK, 32'h0);
    queue_word(dqh_pkg::CMD_UNDO, 32'h0);
    queue_word(dqh_pkg::CMD_UNDO, 32'h0);
    queue_word(dqh_pkg::CMD_REDO, 32'h0);
    queue_word(dqh_pkg::CMD_REDO, 32'h0);
    // Random: bursts that mostly repeat one command kind, so that fills swing to both extremes.
    n = pending_words.size();
    while (n < 950) begin
      logic [2:0] c;
      int burst;
      burst = $urandom_range(1, 20);
      c = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      for (int i = 0; i < burst; i++) begin
        if ($urandom_range(0, 3) == 0) c = 3'($urandom_range(0, 5));
        queue_word(c, random_value());
        n++;
      end
    end
  end

  // Sender.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cmd_i <= '0;
      push_value_i <= '0;
      in_gap <= 0;
      stim_done <= 1'b0;
    end else if (in_valid_i && in_stall_o) begin
      // Hold the word until it is taken.
    end else begin
      if (in_valid_i) begin
        expected_views.insert(expected_views.size(),
                              apply_command('{cmd_i, push_value_i}));
      end
      if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_words.size() != 0) begin
        cmd_word_t w;
        w = pending_words[0];
        pending_words.delete(0);
        in_valid_i <= 1'b1;
        cmd_i <= w.cmd;
        push_value_i <= w.value;
        in_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0;
      end else begin
        in_valid_i <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // Receiver, with one long hold-off partway through.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_gap <= 0;
      hold_cycles <= 0;
    end else begin
      if (cycle_count == 3000) hold_cycles <= 400;
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall_i <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (out_valid_o && $urandom_range(0, 2) == 0) out_gap <= $urandom_range(0, 15);
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      deque_view_t e;
      if (expected_views.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at cycle %0d", cycle_count);
      end else begin
        e = expected_views[0];
        expected_views.delete(0);
        if (popped_value_o !== e.popped || front_value_o !== e.front ||
            back_value_o !== e.back || store_count_o !== e.count ||
            store_empty_o !== e.empty || history_applied_o !== e.applied ||
            undo_entries_o !== e.undo_n || redo_entries_o !== e.redo_n) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp pop=%h f=%h b=%h n=%0d e=%b a=%b u=%0d r=%0d",
                      " got pop=%h f=%h b=%h n=%0d e=%b a=%b u=%0d r=%0d"},
                     e.popped, e.front, e.back, e.count, e.empty, e.applied,
                     e.undo_n, e.redo_n,
                     popped_value_o, front_value_o, back_value_o, store_count_o,
                     store_empty_o, history_applied_o, undo_entries_o, redo_entries_o);
        end
      end
    end
  end

  initial begin
    mismatches = 0;
    cycle_count = 0;
    wait (rst_ni === 1'b1);
    while (!(stim_done && expected_views.size() == 0) && cycle_count < MAX_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    if (cycle_count >= MAX_CYCLES) begin
      $display("FAIL");
    end else begin
      repeat (20) @(posedge clk_i);
      if (mismatches == 0 && expected_views.size() == 0) begin
        $display("PASS");
      end else begin
        $display("FAIL");
      end
    end
    $finish;
  end
endmodule
